// ===== design/fscd_pkg.sv =====
// Shared constants and types for the frame search checksum deframer.
`timescale 1ns / 1ps

package fscd_pkg;

  // Frame layout: head, 4 id bytes, command, joint, 2 length bytes
  localparam int unsigned HDR_BYTES      = 9;
  localparam int unsigned FRAME_OVERHEAD = 11;

  // Configuration register indexes
  localparam logic REG_HEAD = 1'b0;
  localparam logic REG_TAIL = 1'b1;

  typedef logic [7:0] byte_t;

  // Search outcome and captured header of the last candidate
  typedef struct packed {
    logic        done;
    logic        found;
    logic [31:0] dev_id;
    byte_t       cmd;
    byte_t       joint;
    logic [15:0] plen;
  } srch_res_t;

endpackage

// ===== design/frame_search_checksum_deframer_unit.sv =====
// Top level: load/read request control, configuration and result registers.
// A read request's result appears on the cycle after it is accepted;
// loads produce no result unless flagged last.
// A last load holds busy while the search sequencer streams the byte store
// through its single read port, offset by offset; an offset rejected on its
// head byte is left early, a full candidate is read through its payload.
// Reset clears fill count, found state, registers and control; the store is not cleared.
`timescale 1ns / 1ps

module frame_search_checksum_deframer_unit #(
  parameter int unsigned BUF_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        req_type_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  input  logic [9:0]  read_index_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  output logic        valid_o,
  output logic        found_o,
  output logic [9:0]  frame_start_o,
  output logic [31:0] device_id_o,
  output logic [7:0]  command_o,
  output logic [7:0]  joint_id_o,
  output logic [9:0]  payload_len_o,
  output logic [7:0]  read_byte_o
);

  localparam int unsigned AW = $clog2(BUF_DEPTH);
  localparam int unsigned CW = AW + 1;

  fscd_pkg::byte_t     head_q;
  fscd_pkg::byte_t     tail_q;
  logic [CW-1:0]       fill_q;
  logic                found_valid_q;
  logic [AW-1:0]       found_start_q;

  logic                valid_q;
  logic                found_out_q;
  logic [9:0]          fstart_q;
  logic [31:0]         id_out_q;
  fscd_pkg::byte_t     cmd_out_q;
  fscd_pkg::byte_t     joint_out_q;
  logic [9:0]          plen_out_q;
  logic                rb_en_q;

  logic                accept;
  logic                load_req;
  logic                read_req;
  logic                room;
  logic [CW-1:0]       len_new;
  logic                srch_start;
  logic                srch_busy;
  logic                srch_ren;
  logic [AW-1:0]       srch_raddr;
  logic [AW-1:0]       srch_base;
  fscd_pkg::srch_res_t srch_res;
  fscd_pkg::byte_t     ram_rdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [31:0]         rd_addr_ext;
  logic [31:0]         fs_ext;
  logic [31:0]         base_ext;
  logic                rb_en_d;
  logic                valid_d;

  assign accept   = start_i && !busy_o;
  assign load_req = accept && !req_type_i;
  assign read_req = accept && req_type_i;
  assign room     = fill_q < CW'(BUF_DEPTH);
  assign len_new  = fill_q + CW'(room);

  // Start the search only when enough bytes are held for a frame
  assign srch_start = load_req && last_i && (len_new >= CW'(fscd_pkg::FRAME_OVERHEAD));

  // Raise a result for a short last load, a read request or a finished search
  assign valid_d = (load_req && last_i && !srch_start) || read_req || srch_res.done;

  // Payload byte address of a read request
  assign rd_addr_ext = 32'(found_start_q) + 32'(fscd_pkg::HDR_BYTES) + 32'(read_index_i);
  assign fs_ext      = 32'(found_start_q);
  assign base_ext    = 32'(srch_base);
  assign rb_en_d     = found_valid_q && (16'(read_index_i) < srch_res.plen);

  // Share the read port between search and read requests
  assign ram_re    = srch_ren || read_req;
  assign ram_raddr = srch_busy ? srch_raddr : rd_addr_ext[AW-1:0];

  fscd_byte_ram #(
    .DEPTH (BUF_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (load_req && room),
    .waddr_i (fill_q[AW-1:0]),
    .wdata_i (data_byte_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  fscd_search #(
    .DEPTH (BUF_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_search (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (srch_start),
    .len_i   (len_new),
    .head_i  (head_q),
    .tail_i  (tail_q),
    .busy_o  (srch_busy),
    .ren_o   (srch_ren),
    .raddr_o (srch_raddr),
    .rdata_i (ram_rdata),
    .res_o   (srch_res),
    .base_o  (srch_base)
  );

  assign busy_o = srch_busy;

  // Hold configuration, fill count, found state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q        <= '0;
      tail_q        <= '0;
      fill_q        <= '0;
      found_valid_q <= 1'b0;
      found_start_q <= '0;
      valid_q       <= 1'b0;
      found_out_q   <= 1'b0;
      fstart_q      <= '0;
      id_out_q      <= '0;
      cmd_out_q     <= '0;
      joint_out_q   <= '0;
      plen_out_q    <= '0;
      rb_en_q       <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          fscd_pkg::REG_HEAD: head_q <= cfg_wdata_i;
          default:            tail_q <= cfg_wdata_i;
        endcase
      end
      if (load_req) begin
        found_valid_q <= 1'b0;
        fill_q        <= last_i ? '0 : len_new;
        if (last_i && !srch_start) begin
          // Too short for any frame: report nothing found at once
          found_start_q <= '0;
          found_out_q   <= 1'b0;
          fstart_q      <= '0;
          id_out_q      <= '0;
          cmd_out_q     <= '0;
          joint_out_q   <= '0;
          plen_out_q    <= '0;
          rb_en_q       <= 1'b0;
        end
      end else if (read_req) begin
        found_out_q <= found_valid_q;
        fstart_q    <= found_valid_q ? fs_ext[9:0] : '0;
        id_out_q    <= found_valid_q ? srch_res.dev_id : '0;
        cmd_out_q   <= found_valid_q ? srch_res.cmd : '0;
        joint_out_q <= found_valid_q ? srch_res.joint : '0;
        plen_out_q  <= found_valid_q ? srch_res.plen[9:0] : '0;
        rb_en_q     <= rb_en_d;
      end else if (srch_res.done) begin
        found_valid_q <= srch_res.found;
        found_start_q <= srch_res.found ? srch_base : '0;
        found_out_q   <= srch_res.found;
        fstart_q      <= srch_res.found ? base_ext[9:0] : '0;
        id_out_q      <= srch_res.found ? srch_res.dev_id : '0;
        cmd_out_q     <= srch_res.found ? srch_res.cmd : '0;
        joint_out_q   <= srch_res.found ? srch_res.joint : '0;
        plen_out_q    <= srch_res.found ? srch_res.plen[9:0] : '0;
        rb_en_q       <= 1'b0;
      end
    end
  end

  assign valid_o       = valid_q;
  assign found_o       = found_out_q;
  assign frame_start_o = fstart_q;
  assign device_id_o   = id_out_q;
  assign command_o     = cmd_out_q;
  assign joint_id_o    = joint_out_q;
  assign payload_len_o = plen_out_q;
  assign read_byte_o   = rb_en_q ? ram_rdata : '0;

  // A search ends only while the block is busy
  assert property (@(posedge clk_i) disable iff (!rst_ni) srch_res.done |-> busy_o)
    else $error("search done outside busy");

  // Every accepted read request yields a result on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) read_req |=> valid_o)
    else $error("read request without result");

  // A load that is not last produces no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_req && !last_i) |=> !valid_o)
    else $error("result after plain load");

  // A payload byte is only returned for a remembered frame
  assert property (@(posedge clk_i) disable iff (!rst_ni) (valid_o && rb_en_q) |-> found_o)
    else $error("payload byte without frame");

endmodule

// ===== design/fscd_byte_ram.sv =====
// Byte store: one write port, one registered read port.
`timescale 1ns / 1ps

module fscd_byte_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  fscd_pkg::byte_t       wdata_i,
  input  logic                  re_i,
  input  logic [AW-1:0]         raddr_i,
  output fscd_pkg::byte_t       rdata_o
);

  fscd_pkg::byte_t mem [DEPTH];
  fscd_pkg::byte_t rdata_q;

  // Write one byte
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/fscd_search.sv =====
// Frame search sequencer: streams the byte store per candidate offset.
`timescale 1ns / 1ps

module fscd_search #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned CW    = AW + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [CW-1:0]        len_i,
  input  fscd_pkg::byte_t      head_i,
  input  fscd_pkg::byte_t      tail_i,
  output logic                 busy_o,
  output logic                 ren_o,
  output logic [AW-1:0]        raddr_o,
  input  fscd_pkg::byte_t      rdata_i,
  output fscd_pkg::srch_res_t  res_o,
  output logic [AW-1:0]        base_o
);

  localparam int unsigned SW = ((CW > 16) ? CW : 16) + 2;

  typedef enum logic {S_IDLE, S_RUN} state_e;

  state_e          state_q;
  logic [AW-1:0]   base_q;
  logic [CW-1:0]   iss_q;
  logic [CW-1:0]   kp_q;
  logic            vld_q;
  logic [CW-1:0]   len_q;
  fscd_pkg::byte_t sum_q;
  logic [15:0]     plen_q;
  logic [31:0]     id_q;
  fscd_pkg::byte_t cmd_q;
  fscd_pkg::byte_t joint_q;
  logic [SW-1:0]   ck_pos_q;

  logic            abort;
  logic            hit;
  logic            last_cand;
  logic            done;
  logic [15:0]     pl16;
  logic [SW-1:0]   kp_ext;

  assign pl16   = {rdata_i, plen_q[7:0]};
  assign kp_ext = SW'(kp_q);

  // Judge the byte that arrived for offset kp of the current candidate
  always_comb begin
    abort = 1'b0;
    hit   = 1'b0;
    if (state_q == S_RUN && vld_q) begin
      if (kp_q == '0) begin
        if (rdata_i != head_i) abort = 1'b1;
      end else if (kp_q == CW'(8)) begin
        if (SW'(base_q) + SW'(fscd_pkg::FRAME_OVERHEAD) + SW'(pl16) > SW'(len_q)) begin
          abort = 1'b1;
        end
      end else if (kp_q > CW'(8)) begin
        if (kp_ext == ck_pos_q) begin
          if (sum_q != rdata_i) abort = 1'b1;
        end else if (kp_ext == ck_pos_q + SW'(1)) begin
          if (rdata_i == tail_i) hit = 1'b1;
          else abort = 1'b1;
        end
      end
    end
  end

  assign last_cand = (SW'(base_q) + SW'(fscd_pkg::FRAME_OVERHEAD + 1)) > SW'(len_q);
  assign done      = hit || (abort && last_cand);

  // Sequence candidates and capture header bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      base_q   <= '0;
      iss_q    <= '0;
      kp_q     <= '0;
      vld_q    <= 1'b0;
      len_q    <= '0;
      sum_q    <= '0;
      plen_q   <= '0;
      id_q     <= '0;
      cmd_q    <= '0;
      joint_q  <= '0;
      ck_pos_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_RUN;
            base_q  <= '0;
            iss_q   <= '0;
            vld_q   <= 1'b0;
            len_q   <= len_i;
          end
        end
        S_RUN: begin
          if (done) begin
            state_q <= S_IDLE;
            vld_q   <= 1'b0;
          end else if (abort) begin
            base_q <= base_q + AW'(1);
            iss_q  <= '0;
            vld_q  <= 1'b0;
          end else begin
            iss_q <= iss_q + CW'(1);
            kp_q  <= iss_q;
            vld_q <= 1'b1;
          end
          if (vld_q && !abort) begin
            if (kp_q == '0) begin
              sum_q <= '0;
            end else if (kp_q < CW'(9)) begin
              sum_q <= sum_q + rdata_i;
              unique case (kp_q[3:0])
                4'd1:    id_q[7:0]    <= rdata_i;
                4'd2:    id_q[15:8]   <= rdata_i;
                4'd3:    id_q[23:16]  <= rdata_i;
                4'd4:    id_q[31:24]  <= rdata_i;
                4'd5:    cmd_q        <= rdata_i;
                4'd6:    joint_q      <= rdata_i;
                4'd7:    plen_q[7:0]  <= rdata_i;
                default: begin
                  plen_q[15:8] <= rdata_i;
                  ck_pos_q     <= SW'(fscd_pkg::HDR_BYTES) + SW'(pl16);
                end
              endcase
            end else begin
              sum_q <= sum_q + rdata_i;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o  = (state_q == S_RUN);
  assign ren_o   = (state_q == S_RUN);
  assign raddr_o = base_q + iss_q[AW-1:0];
  assign base_o  = base_q;

  assign res_o.done   = done;
  assign res_o.found  = hit;
  assign res_o.dev_id = id_q;
  assign res_o.cmd    = cmd_q;
  assign res_o.joint  = joint_q;
  assign res_o.plen   = plen_q;

endmodule
